FILE: rtl/baf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter package
// Fixed widths, register indexes, reset values and the stage tag type.
// ----------------------------------------------------------------------------
package baf_pkg;

	localparam int ROW_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int FIFO_DEPTH = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;

	typedef struct packed {
		logic clear;
		logic emit;
	} baf_tag_t;

endpackage
`default_nettype wire

FILE: rtl/baf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter stream interfaces
// Pixel channel and mean result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface baf_pixel_if #(
	parameter int PIXEL_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel;
	logic                         start_of_frame;

	modport source (output valid, pixel, start_of_frame, input ready);
	modport sink   (input valid, pixel, start_of_frame, output ready);
endinterface

interface baf_mean_if #(
	parameter int PIXEL_BITS = 16,
	parameter int COL_W      = 10
);
	logic                          valid;
	logic                          ready;
	logic signed [PIXEL_BITS-1:0]  mean_value;
	logic [baf_pkg::ROW_W-1:0]     centre_row;
	logic [COL_W-1:0]              centre_col;
	logic                          frame_done;

	modport source (output valid, mean_value, centre_row, centre_col, frame_done, input ready);
	modport sink   (input valid, mean_value, centre_row, centre_col, frame_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/baf_line_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter line buffer
// Column store of the previous rows, read-modify-write with forwarding, and
// the vertical column sum.
// ----------------------------------------------------------------------------
module baf_line_buf #(
	parameter int MAX_WIDTH     = 1024,
	parameter int WINDOW_RADIUS = 3,
	parameter int PIXEL_BITS    = 16,
	parameter int SIDE_W        = 27,
	localparam int COL_W        = $clog2(MAX_WIDTH),
	localparam int CS_W         = PIXEL_BITS + $clog2(2 * WINDOW_RADIUS + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           acc,
	input  wire  signed [PIXEL_BITS-1:0]  px,
	input  wire         [COL_W-1:0]       col,
	input  wire  baf_pkg::baf_tag_t       tag,
	input  wire         [SIDE_W-1:0]      side,
	output logic                          v_s2,
	output logic signed [CS_W-1:0]        colsum_s2,
	output baf_pkg::baf_tag_t             tag_s2,
	output logic        [SIDE_W-1:0]      side_s2
);

	localparam int LINES  = 2 * WINDOW_RADIUS;
	localparam int LINE_W = LINES * PIXEL_BITS;

	logic [LINE_W-1:0] line_mem [MAX_WIDTH];
	logic [LINE_W-1:0] rd_q;
	logic [LINE_W-1:0] fwd_q;

	logic                         v_s1;
	logic signed [PIXEL_BITS-1:0] px_s1;
	logic [COL_W-1:0]             col_s1;
	logic                         hit_s1;
	baf_pkg::baf_tag_t            tag_s1;
	logic [SIDE_W-1:0]            side_s1;

	logic [LINE_W-1:0]      old_line;
	logic [LINE_W-1:0]      wdata;
	logic signed [CS_W-1:0] colsum;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q <= line_mem[col];
		end
		if (v_s1) begin
			line_mem[col_s1] <= wdata;
		end
	end

	// forward the write of the previous beat when it hits the same column
	assign old_line = hit_s1 ? fwd_q : rd_q;
	assign wdata    = {old_line[LINE_W-PIXEL_BITS-1:0], px_s1};

	always_comb begin
		colsum = CS_W'(px_s1);
		for (int k = 0; k < LINES; k++) begin
			colsum = colsum + CS_W'($signed(old_line[k*PIXEL_BITS +: PIXEL_BITS]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1   <= px;
			col_s1  <= col;
			hit_s1  <= v_s1 && (col == col_s1);
			tag_s1  <= tag;
			side_s1 <= side;
		end
		if (v_s1) begin
			fwd_q     <= wdata;
			colsum_s2 <= colsum;
			tag_s2    <= tag_s1;
			side_s2   <= side_s1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/baf_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter column window
// Sliding row of column sums and the running window total.
// ----------------------------------------------------------------------------
module baf_window #(
	parameter int WINDOW_RADIUS = 3,
	parameter int PIXEL_BITS    = 16,
	parameter int SIDE_W        = 27,
	localparam int WIN_SIDE     = 2 * WINDOW_RADIUS + 1,
	localparam int CS_W         = PIXEL_BITS + $clog2(WIN_SIDE),
	localparam int TOT_W        = PIXEL_BITS + $clog2(WIN_SIDE * WIN_SIDE)
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      v,
	input  wire  signed [CS_W-1:0]   colsum,
	input  wire  baf_pkg::baf_tag_t  tag,
	input  wire         [SIDE_W-1:0] side,
	output logic                     v_s3,
	output logic signed [TOT_W-1:0]  total_s3,
	output logic        [SIDE_W-1:0] side_s3
);

	logic signed [CS_W-1:0]  cs_q [WIN_SIDE];
	logic signed [TOT_W-1:0] total_q;
	logic signed [TOT_W-1:0] total_d;

	// drop the oldest column, add the new one; a row start empties the window
	always_comb begin
		if (tag.clear) begin
			total_d = TOT_W'(colsum);
		end else begin
			total_d = total_q - TOT_W'(cs_q[WIN_SIDE-1]) + TOT_W'(colsum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_SIDE; k++) begin
				cs_q[k] <= '0;
			end
			total_q <= '0;
			v_s3    <= 1'b0;
		end else begin
			v_s3 <= v && tag.emit;
			if (v) begin
				cs_q[0] <= colsum;
				for (int k = 1; k < WIN_SIDE; k++) begin
					cs_q[k] <= tag.clear ? '0 : cs_q[k-1];
				end
				total_q <= total_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v) begin
			total_s3 <= total_d;
			side_s3  <= side;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/baf_mean_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter mean divider
// Rounded division of the window total by the pixel count, by reciprocal
// multiplication over two register stages.
// ----------------------------------------------------------------------------
module baf_mean_div #(
	parameter int WINDOW_RADIUS = 3,
	parameter int PIXEL_BITS    = 16,
	parameter int SIDE_W        = 27,
	localparam int WIN_SIDE     = 2 * WINDOW_RADIUS + 1,
	localparam int TOT_W        = PIXEL_BITS + $clog2(WIN_SIDE * WIN_SIDE)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           v,
	input  wire  signed [TOT_W-1:0]       total,
	input  wire         [SIDE_W-1:0]      side,
	output logic                          v_out,
	output logic signed [PIXEL_BITS-1:0]  mean,
	output logic        [SIDE_W-1:0]      side_out
);

	localparam int     N        = WIN_SIDE * WIN_SIDE;
	localparam int     K        = TOT_W + $clog2(N);
	localparam int     RECIP_W  = TOT_W + 1;
	localparam int     PROD_W   = TOT_W + RECIP_W;
	localparam longint RECIP_L  = ((longint'(1) <<< K) + longint'(N) - 1) / longint'(N);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	logic [TOT_W-1:0]      mag;
	logic                  v_s4;
	logic                  neg_s4;
	logic [TOT_W-1:0]      magp_s4;
	logic [SIDE_W-1:0]     side_s4;
	logic                  v_s5;
	logic                  neg_s5;
	logic [PROD_W-1:0]     prod_s5;
	logic [SIDE_W-1:0]     side_s5;
	logic [PIXEL_BITS:0]   quot;
	logic [PIXEL_BITS:0]   mean_ext;

	assign mag = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= v;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v) begin
			neg_s4  <= total[TOT_W-1];
			magp_s4 <= mag + TOT_W'(N / 2);
			side_s4 <= side;
		end
		if (v_s4) begin
			neg_s5  <= neg_s4;
			prod_s5 <= PROD_W'(magp_s4) * PROD_W'(RECIP);
			side_s5 <= side_s4;
		end
	end

	assign quot     = prod_s5[K +: PIXEL_BITS+1];
	assign mean_ext = neg_s5 ? (PIXEL_BITS+1)'(-quot) : quot;
	assign mean     = $signed(mean_ext[PIXEL_BITS-1:0]);
	assign v_out    = v_s5;
	assign side_out = side_s5;

endmodule
`default_nettype wire

FILE: rtl/baf_result_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter result queue
// Small first-in first-out queue between the pipeline and the result port.
// ----------------------------------------------------------------------------
module baf_result_fifo #(
	parameter int DEPTH = 8,
	parameter int DW    = 43,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [DW-1:0]    din,
	input  wire              pop,
	output logic [DW-1:0]    dout,
	output logic             nonempty,
	output logic [CNT_W-1:0] count
);

	logic [DW-1:0]    slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout     = slot_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign count    = count_q;

endmodule
`default_nettype wire

FILE: rtl/box_average_filter_7x7_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Box average filter core, 7x7
// Streaming box mean over a raster pixel stream, one result per full window.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, as long as results are drained; the
// figure is set by the single line memory, which is read once and written once
// per pixel. A result passes the memory read, column sum, window total, two
// divider stages and the result queue before it appears on the output. The
// line memory needs no clearing after reset. Register writes apply to the next
// pixel; only write them while the core is idle.
// ----------------------------------------------------------------------------
module box_average_filter_7x7_core #(
	parameter int MAX_WIDTH     = 1024,
	parameter int WINDOW_RADIUS = 3,
	parameter int PIXEL_BITS    = 16,
	localparam int COL_W        = $clog2(MAX_WIDTH),
	localparam int FW_W         = COL_W + 1,
	localparam int CFG_W        = (FW_W > baf_pkg::ROW_W) ? FW_W : baf_pkg::ROW_W
) (
	input  wire                             clk,
	input  wire                             arst_n,
	baf_pixel_if.sink                       pix,
	baf_mean_if.source                      res,
	input  wire                             cfg_we,
	input  wire  [baf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_W-1:0]                cfg_data
);

	localparam int ROW_W    = baf_pkg::ROW_W;
	localparam int LINES    = 2 * WINDOW_RADIUS;
	localparam int WIN_SIDE = 2 * WINDOW_RADIUS + 1;
	localparam int CS_W     = PIXEL_BITS + $clog2(WIN_SIDE);
	localparam int TOT_W    = PIXEL_BITS + $clog2(WIN_SIDE * WIN_SIDE);
	localparam int SIDE_W   = 1 + ROW_W + COL_W;
	localparam int DEPTH    = baf_pkg::FIFO_DEPTH;
	localparam int CR_W     = $clog2(DEPTH + 1);
	localparam int RES_W    = PIXEL_BITS + SIDE_W;

	logic [FW_W-1:0]  frame_width_q;
	logic [ROW_W-1:0] frame_height_q;
	logic [COL_W-1:0] col_count_q;
	logic [ROW_W-1:0] row_count_q;
	logic [CR_W-1:0]  credit_q;

	logic [FW_W-1:0]  w_eff;
	logic [ROW_W-1:0] h_eff;
	logic [COL_W-1:0] col_base;
	logic [COL_W-1:0] col_cur;
	logic [ROW_W-1:0] row_base;
	logic [ROW_W-1:0] row_cur;
	logic [FW_W-1:0]  col_inc;
	logic [ROW_W:0]   row_inc;
	logic             col_wrap;
	logic             row_wrap;
	logic             acc;

	baf_pkg::baf_tag_t tag_s0;
	logic [SIDE_W-1:0] side_s0;

	logic                         lb_v;
	logic signed [CS_W-1:0]       lb_colsum;
	baf_pkg::baf_tag_t            lb_tag;
	logic [SIDE_W-1:0]            lb_side;
	logic                         win_v;
	logic signed [TOT_W-1:0]      win_total;
	logic [SIDE_W-1:0]            win_side;
	logic                         div_v;
	logic signed [PIXEL_BITS-1:0] div_mean;
	logic [SIDE_W-1:0]            div_side;
	logic [RES_W-1:0]             fifo_dout;
	logic                         fifo_nonempty;
	logic [CR_W-1:0]              fifo_count;
	logic                         drop;
	logic                         pop;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_W'(baf_pkg::FRAME_WIDTH_RST);
			frame_height_q <= ROW_W'(baf_pkg::FRAME_HEIGHT_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				baf_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FW_W-1:0];
				baf_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// position of the incoming pixel
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = FW_W'(1);
		end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
			w_eff = FW_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		h_eff    = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;
		col_base = pix.start_of_frame ? '0 : col_count_q;
		row_base = pix.start_of_frame ? '0 : row_count_q;
		col_cur  = ({1'b0, col_base} >= w_eff) ? '0 : col_base;
		row_cur  = (row_base >= h_eff) ? '0 : row_base;
		col_inc  = {1'b0, col_cur} + FW_W'(1);
		row_inc  = {1'b0, row_cur} + (ROW_W+1)'(1);
		col_wrap = (col_inc >= w_eff);
		row_wrap = (row_inc >= {1'b0, h_eff});
	end

	assign tag_s0.clear = (col_cur == '0);
	assign tag_s0.emit  = (row_cur >= ROW_W'(LINES)) && (col_cur >= COL_W'(LINES));
	assign side_s0      = {col_wrap && row_wrap,
		row_cur - ROW_W'(WINDOW_RADIUS), col_cur - COL_W'(WINDOW_RADIUS)};

	assign pix.ready = (credit_q < CR_W'(DEPTH));
	assign acc       = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_count_q <= '0;
				row_count_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_count_q <= col_inc[COL_W-1:0];
				row_count_q <= row_cur;
			end
		end
	end

	baf_line_buf #(
		.MAX_WIDTH     (MAX_WIDTH),
		.WINDOW_RADIUS (WINDOW_RADIUS),
		.PIXEL_BITS    (PIXEL_BITS),
		.SIDE_W        (SIDE_W)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.px        (pix.pixel),
		.col       (col_cur),
		.tag       (tag_s0),
		.side      (side_s0),
		.v_s2      (lb_v),
		.colsum_s2 (lb_colsum),
		.tag_s2    (lb_tag),
		.side_s2   (lb_side)
	);

	baf_window #(
		.WINDOW_RADIUS (WINDOW_RADIUS),
		.PIXEL_BITS    (PIXEL_BITS),
		.SIDE_W        (SIDE_W)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.v        (lb_v),
		.colsum   (lb_colsum),
		.tag      (lb_tag),
		.side     (lb_side),
		.v_s3     (win_v),
		.total_s3 (win_total),
		.side_s3  (win_side)
	);

	baf_mean_div #(
		.WINDOW_RADIUS (WINDOW_RADIUS),
		.PIXEL_BITS    (PIXEL_BITS),
		.SIDE_W        (SIDE_W)
	) u_mean_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.v        (win_v),
		.total    (win_total),
		.side     (win_side),
		.v_out    (div_v),
		.mean     (div_mean),
		.side_out (div_side)
	);

	baf_result_fifo #(
		.DEPTH (DEPTH),
		.DW    (RES_W)
	) u_result_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (div_v),
		.din      ({div_mean, div_side}),
		.pop      (pop),
		.dout     (fifo_dout),
		.nonempty (fifo_nonempty),
		.count    (fifo_count)
	);

	assign res.valid      = fifo_nonempty;
	assign pop            = res.valid && res.ready;
	assign res.mean_value = $signed(fifo_dout[RES_W-1 -: PIXEL_BITS]);
	assign res.frame_done = fifo_dout[SIDE_W-1];
	assign res.centre_row = fifo_dout[COL_W +: ROW_W];
	assign res.centre_col = fifo_dout[COL_W-1:0];

	// beats in flight or queued; a pixel with no result retires at the window
	assign drop = lb_v && !lb_tag.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CR_W'(acc) - CR_W'(drop) - CR_W'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CR_W'(DEPTH))
		else $error("beats in flight exceed result queue depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= credit_q)
		else $error("result queue holds more beats than were taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##2 lb_v)
		else $error("column sum missing two cycles after a pixel beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_v |-> (fifo_count < CR_W'(DEPTH)) || pop)
		else $error("result pushed into a full queue");

endmodule
`default_nettype wire

FILE: tb/baf_mean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average filter checker
// Follows the register port and the pixel channel, works out each 7x7 mean
// that a taken pixel completes, and compares every beat on the mean channel
// with the oldest mean still owed, field by field.
// ----------------------------------------------------------------------------
module baf_mean_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	baf_pixel_if                         pix,
	baf_mean_if                          res,
	input  wire                          cfg_we,
	input  wire [baf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [15:0]                   cfg_data,
	output int                           fail_count,
	output int                           pending
);

	localparam int RADIUS    = 3;
	localparam int SIDE      = 2 * RADIUS + 1;
	localparam int LINES     = 2 * RADIUS;
	localparam int AREA      = SIDE * SIDE;
	localparam int MAX_WIDTH = 1024;

	typedef struct packed {
		logic [15:0] mean_value;
		logic [15:0] centre_row;
		logic [9:0]  centre_col;
		logic        frame_done;
	} mean_t;

	logic signed [15:0] line_mem [MAX_WIDTH][LINES];
	logic signed [18:0] col_sums [SIDE];
	logic signed [21:0] box_sum;
	logic [15:0]        row_pos;
	logic [9:0]         col_pos;
	logic [10:0]        width_reg;
	logic [15:0]        height_reg;
	mean_t              means_due [$];
	int                 mismatches;

	task automatic take_pixel(input logic [15:0] raw, input logic sof);
		int w, h, r, c, col_total, sum_now, mag, q;
		mean_t m;
		w = (width_reg == '0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
		h = (height_reg == '0) ? 1 : int'(height_reg);
		if (sof) begin
			row_pos = '0;
			col_pos = '0;
		end
		if (col_pos >= w) col_pos = '0;
		if (row_pos >= h) row_pos = '0;
		r = row_pos;
		c = col_pos;
		if (c == 0) begin
			foreach (col_sums[k]) col_sums[k] = '0;
			box_sum = '0;
		end
		col_total = $signed(raw);
		for (int k = 0; k < LINES; k++) col_total += line_mem[c][k];
		for (int k = LINES - 1; k > 0; k--) line_mem[c][k] = line_mem[c][k - 1];
		line_mem[c][0] = raw;
		box_sum = box_sum - col_sums[SIDE - 1] + col_total;
		for (int k = SIDE - 1; k > 0; k--) col_sums[k] = col_sums[k - 1];
		col_sums[0] = col_total;
		if (r >= LINES && c >= LINES) begin
			sum_now = box_sum;
			mag = (sum_now < 0) ? -sum_now : sum_now;
			q = (mag + AREA / 2) / AREA;
			m.mean_value = 16'((sum_now < 0) ? -q : q);
			m.centre_row = 16'(r - RADIUS);
			m.centre_col = 10'(c - RADIUS);
			m.frame_done = (r == h - 1) && (c == w - 1);
			means_due.push_back(m);
		end
		if (c + 1 >= w) begin
			col_pos = '0;
			row_pos = (r + 1 >= h) ? '0 : 16'(r + 1);
		end else begin
			col_pos = 10'(c + 1);
		end
	endtask

	task automatic compare_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	task automatic check_mean();
		mean_t want;
		if (means_due.size() == 0) begin
			$error("mean beat with nothing owed: row %0d col %0d", res.centre_row, res.centre_col);
			mismatches++;
		end else begin
			want = means_due.pop_front();
			compare_field("mean_value", $signed(want.mean_value), $signed(res.mean_value));
			compare_field("centre_row", want.centre_row, res.centre_row);
			compare_field("centre_col", want.centre_col, res.centre_col);
			compare_field("frame_done", want.frame_done, res.frame_done);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatches = 0;
			means_due.delete();
			foreach (line_mem[i, j]) line_mem[i][j] = '0;
			foreach (col_sums[k]) col_sums[k] = '0;
			box_sum = '0;
			row_pos = '0;
			col_pos = '0;
			width_reg = 11'(baf_pkg::FRAME_WIDTH_RST);
			height_reg = 16'(baf_pkg::FRAME_HEIGHT_RST);
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					baf_pkg::CFG_FRAME_WIDTH: width_reg = cfg_data[10:0];
					baf_pkg::CFG_FRAME_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (res.valid && res.ready) check_mean();
			if (pix.valid && pix.ready) take_pixel(pix.pixel, pix.start_of_frame);
			fail_count <= mismatches;
			pending <= means_due.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box average filter testbench
// Streams raster frames of many sizes through the 7x7 core: a short run at the
// reset size, the smallest full window, clamped and degenerate sizes, a very
// tall frame and random small frames, some cut short or restarted mid-frame.
// Both channels idle at random and the mean side stalls once for a long
// stretch while pixels keep coming.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [15:0] PIX_MAX        = 16'h7fff;
	localparam logic [15:0] PIX_MIN        = 16'h8000;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          SETTLE_CYCLES  = 10;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RANDOM_ITEMS   = 200;

	typedef enum int {FILL_RANDOM, FILL_MAX, FILL_MIN, FILL_EXTREME} fill_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [baf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [15:0]                   cfg_data;
	int                            fail_count;
	int                            pending;
	int                            hold_asks = 0;
	int                            idle_cycles = 0;
	int                            src_stretch = 0;
	bit                            src_quiet = 1'b0;
	bit                            src_pinned = 1'b0;
	int                            cur_width;

	baf_pixel_if pix_if ();
	baf_mean_if  res_if ();

	box_average_filter_7x7_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	baf_mean_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix_if),
		.res        (res_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic int pick_idle();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60) return 0;
		if (roll < 95) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [15:0] pick_pixel(input fill_t fill);
		case (fill)
			FILL_MAX: return PIX_MAX;
			FILL_MIN: return PIX_MIN;
			FILL_EXTREME: begin
				case ($urandom_range(3))
					0: return PIX_MAX;
					1: return PIX_MIN;
					2: return 16'($urandom_range(255)) - 16'd128;
					default: return 16'($urandom);
				endcase
			end
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_pixel(input logic [15:0] value, input logic sof);
		int gap;
		if (src_stretch == 0) begin
			src_quiet = ($urandom_range(2) == 0);
			src_stretch = $urandom_range(200, 30);
		end
		src_stretch--;
		gap = (src_quiet || src_pinned) ? 0 : pick_idle();
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel <= value;
		pix_if.start_of_frame <= sof;
		do @(posedge clk); while (!pix_if.ready);
		@(negedge clk);
	endtask

	task automatic run_pixels(input int count, input fill_t fill, input bit sof_first,
			input int restart_at);
		for (int i = 0; i < count; i++)
			send_pixel(pick_pixel(fill), (i == 0 && sof_first) || i == restart_at);
	endtask

	task automatic drain();
		pix_if.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_frame(input logic [10:0] width, input logic [15:0] height);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= baf_pkg::CFG_FRAME_WIDTH;
		cfg_data <= {5'($urandom), width};
		@(negedge clk);
		cfg_index <= baf_pkg::CFG_FRAME_HEIGHT;
		cfg_data <= height;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_width = (width == '0) ? 1 : ((width > 1024) ? 1024 : int'(width));
	endtask

	initial begin
		int w, h, frames, count, restart_at, random_items;
		bit sof_first;
		fill_t fill;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = baf_pkg::CFG_FRAME_WIDTH;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		pix_if.start_of_frame = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cur_width = baf_pkg::FRAME_WIDTH_RST;
		run_pixels(40, FILL_RANDOM, 1'b1, -1);

		set_frame(11'd7, 16'd7);
		run_pixels(49, FILL_MAX, 1'b1, -1);
		run_pixels(49, FILL_MIN, 1'b0, -1);
		run_pixels(49, FILL_EXTREME, 1'b0, 20);

		set_frame(11'd0, 16'd0);
		run_pixels(20, FILL_RANDOM, 1'b1, -1);
		set_frame(11'd6, 16'd10);
		run_pixels(60, FILL_RANDOM, 1'b1, -1);
		set_frame(11'h7ff, 16'd7);
		run_pixels(30, FILL_EXTREME, 1'b1, -1);
		set_frame(11'd9, 16'hffff);
		run_pixels(9 * 8, FILL_RANDOM, 1'b1, -1);

		// hold the mean side so the core backs up its pixel input
		set_frame(11'd16, 16'd8);
		hold_asks++;
		src_pinned = 1'b1;
		run_pixels(16 * 8, FILL_EXTREME, 1'b1, -1);
		src_pinned = 1'b0;

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			w = ($urandom_range(7) == 0) ? $urandom_range(24, 17) : $urandom_range(16, 7);
			h = $urandom_range(10, 7);
			sof_first = (w > cur_width) || ($urandom_range(2) != 0);
			set_frame(11'(w), 16'(h));
			frames = $urandom_range(2, 1);
			count = w * h * frames;
			if ($urandom_range(3) == 0) count -= $urandom_range(w * h - 1);
			restart_at = ($urandom_range(4) == 0) ? $urandom_range(count - 1) : -1;
			fill = ($urandom_range(1) == 0) ? FILL_RANDOM : fill_t'($urandom_range(3));
			run_pixels(count, fill, sof_first, restart_at);
			random_items += count;
		end
		drain();

		if (fail_count == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end

	initial begin
		int stall, holds_done, stretch;
		bit quiet;
		holds_done = 0;
		stretch = 0;
		quiet = 1'b0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done < hold_asks) begin
				holds_done++;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (stretch == 0) begin
				quiet = ($urandom_range(2) == 0);
				stretch = $urandom_range(200, 30);
			end
			stretch--;
			stall = quiet ? 0 : pick_idle();
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
